// ===== hw/rtl/mpd2x_pkg.sv =====
// Shared types and pixel expansion function for the 2x monochrome pixel doubler.
`timescale 1ns / 1ps
package mpd2x_pkg;

  localparam int RowBytesDefault = 20;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // take the input byte: store it and load the result register
    logic issue_read; // read the next stored byte of the row
    logic load_read;  // load the result register from the read data
  } mpd2x_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_last;   // result register holds the final result of its transaction
  } mpd2x_status_t;

  // Double each pixel horizontally; returns {left, right}
  function automatic logic [15:0] expand_byte(input logic [7:0] v, input logic high_lead);
    logic [7:0] first_half;
    logic [7:0] second_half;
    logic [3:0] a;
    logic [3:0] b;
    a = high_lead ? v[7:4] : v[3:0];
    b = high_lead ? v[3:0] : v[7:4];
    first_half  = {a[3], a[3], a[2], a[2], a[1], a[1], a[0], a[0]};
    second_half = {b[3], b[3], b[2], b[2], b[1], b[1], b[0], b[0]};
    return {first_half, second_half};
  endfunction

endpackage

// ===== hw/rtl/mpd2x_ctrl.sv =====
// Controller state machine: sequences capture, result hand-off and row replay.
`timescale 1ns / 1ps
module mpd2x_ctrl
  import mpd2x_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  mpd2x_status_t status,
  output mpd2x_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_OUT  = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd.capture    = 1'b0;
    cmd.issue_read = 1'b0;
    cmd.load_read  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (status.out_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.issue_read = 1'b1;
            state_next     = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.load_read = 1'b1;
        state_next    = S_OUT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // Commands never overlap
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.issue_read, cmd.load_read}))
    else $error("overlapping datapath commands");

  // A read is always followed by a load of the read data
  assert property (@(posedge clk) disable iff (rst)
    cmd.issue_read |=> cmd.load_read)
    else $error("read issued without load");

  // Capture only happens with no result pending
  assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !out_valid)
    else $error("capture while a result is pending");

endmodule

// ===== hw/rtl/mpd2x_datapath.sv =====
// Datapath: line store, column and replay counters, result register, expansion.
`timescale 1ns / 1ps
module mpd2x_datapath
  import mpd2x_pkg::*;
#(
  parameter int ROW_BYTES = RowBytesDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_data,
  input  logic [7:0]    frame_byte,
  input  mpd2x_cmd_t    cmd,
  output mpd2x_status_t status,
  output logic [7:0]    left_byte,
  output logic [7:0]    right_byte,
  output logic          repeat_line,
  output logic          run_last
);

  localparam int CntW  = $clog2(ROW_BYTES + 1);
  localparam int AddrW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam logic [CntW-1:0] LastCol = CntW'(ROW_BYTES - 1);
  localparam logic [CntW-1:0] RowLen  = CntW'(ROW_BYTES);

  logic             pixel_msb_first;
  logic [CntW-1:0]  column_index;
  logic [CntW-1:0]  replay_cnt;
  logic [7:0]       line_store [ROW_BYTES];
  logic [7:0]       rd_data;
  logic [7:0]       out_byte;
  logic             out_rep;
  logic             out_last;
  logic             row_end;
  logic [CntW-1:0]  wr_col;
  logic [15:0]      expanded;

  assign row_end = (column_index >= LastCol);
  assign wr_col  = row_end ? LastCol : column_index;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_msb_first <= 1'b0;
    end else if (cfg_write) begin
      pixel_msb_first <= cfg_data;
    end
  end

  // Column and replay counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      replay_cnt   <= '0;
    end else if (cmd.capture) begin
      column_index <= row_end ? '0 : column_index + 1'b1;
      replay_cnt   <= '0;
    end else if (cmd.issue_read) begin
      replay_cnt <= replay_cnt + 1'b1;
    end
  end

  // Line store: write on capture, registered read on replay
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      line_store[wr_col[AddrW-1:0]] <= frame_byte;
    end
    if (cmd.issue_read) begin
      rd_data <= line_store[replay_cnt[AddrW-1:0]];
    end
  end

  // Result register holds the raw byte and its flags
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_byte <= frame_byte;
      out_rep  <= 1'b0;
      out_last <= !row_end;
    end else if (cmd.load_read) begin
      out_byte <= rd_data;
      out_rep  <= 1'b1;
      out_last <= (replay_cnt == RowLen);
    end
  end

  // Expand with the pixel order in force
  assign expanded        = expand_byte(out_byte, pixel_msb_first);
  assign left_byte       = expanded[15:8];
  assign right_byte      = expanded[7:0];
  assign repeat_line     = out_rep;
  assign run_last        = out_last;
  assign status.out_last = out_last;

endmodule

// ===== hw/rtl/mono_pixel_doubler_2x.sv =====
// Top level of the 2x nearest-neighbor upscaler for 1-bit-per-pixel frames.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall / frame_byte) takes one packed source
//   byte of the current row per transaction. Each byte yields a transaction
//   on the output channel (out_valid / out_stall / left_byte, right_byte,
//   repeat_line, run_last) carrying the byte doubled horizontally.
//   After the last byte of a row, the stored row is replayed as the second,
//   vertically doubled line (repeat_line = 1); run_last marks the final
//   result caused by an input byte.
//   The result is valid in the cycle after the input transaction.
//   A new byte is taken only once all results of the last one are taken;
//   the byte that ends a row holds the input until the stored row has been
//   replayed, each replayed result coming from a registered line-store read.
//   cfg_write / cfg_data set the pixel order (1: leftmost pixel is bit 7);
//   write only while idle.
//   Reset (rst, synchronous) clears the pixel order and the column position.
//   A stalled output holds its result and keeps in_stall high until taken.
module mono_pixel_doubler_2x
  import mpd2x_pkg::*;
#(
  parameter int ROW_BYTES = RowBytesDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] frame_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] left_byte,
  output logic [7:0] right_byte,
  output logic       repeat_line,
  output logic       run_last
);

  mpd2x_cmd_t    cmd;
  mpd2x_status_t status;

  mpd2x_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mpd2x_datapath #(
    .ROW_BYTES (ROW_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .frame_byte  (frame_byte),
    .cmd         (cmd),
    .status      (status),
    .left_byte   (left_byte),
    .right_byte  (right_byte),
    .repeat_line (repeat_line),
    .run_last    (run_last)
  );

  // An accepted byte shows its immediate result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (out_valid && !repeat_line))
    else $error("immediate result missing");

  // A result without run_last is followed by a replayed result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !run_last) |=> ##1 (out_valid && repeat_line))
    else $error("replay did not continue");

  // No input is taken while a result is pending
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted with result pending");

endmodule

// ===== tb/pixel_double_checker.sv =====
// Checker for the 2x pixel doubler: predicts every output transaction and compares it.
`timescale 1ns / 1ps
module pixel_double_checker #(
  parameter int ROW_BYTES = mpd2x_pkg::RowBytesDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] frame_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] left_byte,
  input  logic [7:0] right_byte,
  input  logic       repeat_line,
  input  logic       run_last,
  output int         mismatch_count,
  output int         words_outstanding
);

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    logic       rep;
    logic       last;
  } doubled_word_t;

  logic          msb_order;
  logic [5:0]    column;
  logic [7:0]    row_copy [ROW_BYTES];
  doubled_word_t pending_words [$];
  int            fails;

  // Double each source pixel into two display pixels, returns {left, right}
  function automatic logic [15:0] double_pixels(input logic [7:0] src, input logic msb);
    logic [7:0] lft;
    logic [7:0] rgt;
    int         spos;
    int         d;
    int         dpos;
    lft = '0;
    rgt = '0;
    for (int p = 0; p < 8; p++) begin
      spos = msb ? 7 - p : p;
      if (src[spos]) begin
        for (int k = 0; k < 2; k++) begin
          d    = 2 * p + k;
          dpos = msb ? 7 - (d % 8) : d % 8;
          if (d < 8) lft[dpos] = 1'b1;
          else rgt[dpos] = 1'b1;
        end
      end
    end
    return {lft, rgt};
  endfunction

  function automatic doubled_word_t make_word(input logic [7:0] src, input logic rep,
                                              input logic last);
    doubled_word_t w;
    {w.left, w.right} = double_pixels(src, msb_order);
    w.rep  = rep;
    w.last = last;
    return w;
  endfunction

  always @(posedge clk) begin
    doubled_word_t exp_w;
    logic          row_end;
    logic [5:0]    slot;
    if (rst) begin
      msb_order = 1'b0;
      column    = '0;
      pending_words.delete();
      fails     = 0;
    end else begin
      // Compare an accepted result with the oldest expectation
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected result left=%h right=%h rep=%b last=%b",
                     $realtime, left_byte, right_byte, repeat_line, run_last);
          fails++;
        end else begin
          exp_w = pending_words.pop_front();
          if (exp_w.left !== left_byte || exp_w.right !== right_byte ||
              exp_w.rep !== repeat_line || exp_w.last !== run_last) begin
            if (fails < 10)
              $display("%0t: mismatch exp left=%h right=%h rep=%b last=%b, got %h %h %b %b",
                       $realtime, exp_w.left, exp_w.right, exp_w.rep, exp_w.last,
                       left_byte, right_byte, repeat_line, run_last);
            fails++;
          end
        end
      end
      // Store the byte, queue its word and the replayed row at the row end
      if (in_valid && !in_stall) begin
        row_end = column >= 6'(ROW_BYTES - 1);
        slot    = row_end ? 6'(ROW_BYTES - 1) : column;
        row_copy[slot] = frame_byte;
        pending_words.push_back(make_word(frame_byte, 1'b0, !row_end));
        if (row_end) begin
          for (int c = 0; c < ROW_BYTES; c++)
            pending_words.push_back(make_word(row_copy[c], 1'b1, c == ROW_BYTES - 1));
          column = '0;
        end else begin
          column = column + 6'd1;
        end
      end
      // Track the pixel order register
      if (cfg_write) msb_order = cfg_data;
    end
    mismatch_count    <= fails;
    words_outstanding <= pending_words.size();
  end

endmodule

// ===== tb/tb_mono_pixel_doubler_2x.sv =====
// Testbench top for the 2x pixel doubler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_mono_pixel_doubler_2x;

  localparam int RowBytes = mpd2x_pkg::RowBytesDefault;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic       cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] frame_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] left_byte;
  logic [7:0] right_byte;
  logic       repeat_line;
  logic       run_last;
  int         mismatch_count;
  int         words_outstanding;
  logic       steady;

  mono_pixel_doubler_2x #(.ROW_BYTES(RowBytes)) dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .frame_byte(frame_byte),
    .out_valid(out_valid), .out_stall(out_stall), .left_byte(left_byte),
    .right_byte(right_byte), .repeat_line(repeat_line), .run_last(run_last)
  );

  pixel_double_checker #(.ROW_BYTES(RowBytes)) u_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .frame_byte(frame_byte),
    .out_valid(out_valid), .out_stall(out_stall), .left_byte(left_byte),
    .right_byte(right_byte), .repeat_line(repeat_line), .run_last(run_last),
    .mismatch_count(mismatch_count), .words_outstanding(words_outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the output at random unless in a steady stretch
  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 13);
  end

  // Offer one byte, idling first at random, and hold it until the transaction
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    frame_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_order(input logic msb);
    cfg_write <= 1'b1;
    cfg_data  <= msb;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [7:0] edge_bytes [10];
    int         split;
    edge_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h3C, 8'hC3};
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_data   = 1'b0;
    in_valid   = 1'b0;
    frame_byte = '0;
    steady     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed row: edge patterns in LSB-first order, then flip order mid-row
    for (int i = 0; i < 10; i++) send_byte(edge_bytes[i]);
    wait_drained();
    set_order(1'b1);
    for (int i = 0; i < RowBytes - 10; i++) send_byte(edge_bytes[(i + 3) % 10]);
    wait_drained();
    set_order(1'b0);

    // Random rows, some with an order change at a random column
    for (int row = 0; row < 13; row++) begin
      steady = (row >= 2 && row <= 4);
      split  = ($urandom_range(2) == 0) ? $urandom_range(RowBytes - 1) : -1;
      for (int col = 0; col < RowBytes; col++) begin
        if (col == split) begin
          wait_drained();
          set_order(1'($urandom_range(1)));
        end
        send_byte(pick_byte());
      end
      if ($urandom_range(3) == 0) begin
        wait_drained();
        set_order(1'($urandom_range(1)));
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && words_outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== mono_pixel_doubler_2x.f =====
hw/rtl/mpd2x_pkg.sv
hw/rtl/mpd2x_ctrl.sv
hw/rtl/mpd2x_datapath.sv
hw/rtl/mono_pixel_doubler_2x.sv
tb/pixel_double_checker.sv
tb/tb_mono_pixel_doubler_2x.sv
